// ----- rtl/ffms_pkg.sv -----
// shared types and constants of the flow field metropolis step block
`default_nettype none

package ffms_pkg;

  // default grid and table sizes
  localparam int DEF_GRID_ROWS       = 64;
  localparam int DEF_GRID_COLS       = 64;
  localparam int DEF_EXP_TABLE_DEPTH = 256;

  localparam int CFG_INDEX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DENSITY_FLOW_GAIN   = 3'd0,
    CFG_FLOW_DENSITY_GAIN   = 3'd1,
    CFG_SMOOTHNESS_WEIGHT   = 3'd2,
    CFG_TARGET_WEIGHT       = 3'd3,
    CFG_INVERSE_TEMPERATURE = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_SPARE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SETTLE,
    ST_CALC,
    ST_LOOK,
    ST_TABLE,
    ST_FINISH
  } state_t;

  // read phases of a step
  typedef logic [2:0] phase_t;
  localparam phase_t PH_CENTER = 3'd0;
  localparam phase_t PH_UP     = 3'd1;
  localparam phase_t PH_DOWN   = 3'd2;
  localparam phase_t PH_LEFT   = 3'd3;
  localparam phase_t PH_RIGHT  = 3'd4;

  // product schedule of the shared multiplier
  typedef logic [4:0] op_idx_t;
  localparam op_idx_t OP_RAW0   = 5'd0;   // increment times density difference
  localparam op_idx_t OP_SQ0    = 5'd4;   // smoothness squares
  localparam op_idx_t OP_TGT0   = 5'd20;  // target squares
  localparam op_idx_t OP_GAIN0  = 5'd24;  // density terms times gain
  localparam op_idx_t OP_SMW    = 5'd28;
  localparam op_idx_t OP_TGW    = 5'd29;
  localparam op_idx_t OP_ENERGY = 5'd30;
  localparam op_idx_t OP_COUNT  = 5'd31;

  localparam logic signed [47:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q48_MIN = 48'sh8000_0000_0000;
  localparam logic signed [31:0] Q32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] density;
    logic signed [31:0] target_u;
    logic signed [31:0] target_v;
    logic signed [31:0] trial_du;
    logic signed [31:0] trial_dv;
    logic [15:0]        uniform_draw;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               bad_site;
    logic signed [47:0] energy_change;
    logic signed [31:0] flow_u;
    logic signed [31:0] flow_v;
    logic [31:0]        accept_total;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/flow_field_metropolis_step.sv -----
// top level of the flow field metropolis step block
`default_nettype none

// channel   direction  handshake                 payload
// item      in         item_valid / item_ready   item (item_t)
// result    out        result_valid / result_ready result (result_t)
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// load, read and spare items and rejected sites go through fetch and settle
// to the final state; a good step also runs the calc, look and table states,
// with the one shared multiplier pipeline forming its 31 products in turn.
// after each item the block returns to idle, where the next item is taken.
// reset is synchronous, clears control state and move count, presets config.
// the result sits in its own register, so the next item is taken while it
// waits; a stalled result only holds the block at its final state.

module flow_field_metropolis_step
  import ffms_pkg::*;
#(
  parameter int GRID_ROWS       = DEF_GRID_ROWS,
  parameter int GRID_COLS       = DEF_GRID_COLS,
  parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int Cells   = GRID_ROWS * GRID_COLS;
  localparam int AddrW   = $clog2(Cells);
  localparam int ExpIdxW = $clog2(EXP_TABLE_DEPTH);

  localparam logic [AddrW-1:0] Col1 = AddrW'(GRID_COLS);
  localparam logic [AddrW-1:0] Col2 = AddrW'(2 * GRID_COLS);
  localparam logic [AddrW-1:0] One  = AddrW'(1);
  localparam logic [AddrW-1:0] Two  = AddrW'(2);

  // exp(-16/depth) in Q0.31 from a truncated taylor sum
  localparam longint unsigned ExpD   = longint'(EXP_TABLE_DEPTH);
  localparam longint unsigned ExpT1  = (64'd1 << 35) / (ExpD * 1);
  localparam longint unsigned ExpT2  = ExpT1 * 16 / (ExpD * 2);
  localparam longint unsigned ExpT3  = ExpT2 * 16 / (ExpD * 3);
  localparam longint unsigned ExpT4  = ExpT3 * 16 / (ExpD * 4);
  localparam longint unsigned ExpT5  = ExpT4 * 16 / (ExpD * 5);
  localparam longint unsigned ExpT6  = ExpT5 * 16 / (ExpD * 6);
  localparam longint unsigned ExpT7  = ExpT6 * 16 / (ExpD * 7);
  localparam longint unsigned ExpT8  = ExpT7 * 16 / (ExpD * 8);
  localparam longint unsigned ExpT9  = ExpT8 * 16 / (ExpD * 9);
  localparam longint unsigned ExpT10 = ExpT9 * 16 / (ExpD * 10);
  localparam longint unsigned ExpT11 = ExpT10 * 16 / (ExpD * 11);
  localparam longint unsigned ExpT12 = ExpT11 * 16 / (ExpD * 12);
  localparam longint unsigned ExpT13 = ExpT12 * 16 / (ExpD * 13);
  localparam longint unsigned ExpT14 = ExpT13 * 16 / (ExpD * 14);
  localparam longint unsigned ExpT15 = ExpT14 * 16 / (ExpD * 15);
  localparam longint unsigned ExpT16 = ExpT15 * 16 / (ExpD * 16);
  localparam longint unsigned ExpT17 = ExpT16 * 16 / (ExpD * 17);
  localparam longint unsigned ExpT18 = ExpT17 * 16 / (ExpD * 18);
  localparam longint unsigned ExpT19 = ExpT18 * 16 / (ExpD * 19);
  localparam longint unsigned ExpT20 = ExpT19 * 16 / (ExpD * 20);
  localparam longint unsigned ExpT21 = ExpT20 * 16 / (ExpD * 21);
  localparam longint unsigned ExpT22 = ExpT21 * 16 / (ExpD * 22);
  localparam longint unsigned ExpT23 = ExpT22 * 16 / (ExpD * 23);
  localparam longint unsigned ExpT24 = ExpT23 * 16 / (ExpD * 24);
  localparam longint unsigned ExpRatio = (64'd1 << 31)
    - ExpT1 + ExpT2 - ExpT3 + ExpT4 - ExpT5 + ExpT6 - ExpT7 + ExpT8
    - ExpT9 + ExpT10 - ExpT11 + ExpT12 - ExpT13 + ExpT14 - ExpT15 + ExpT16
    - ExpT17 + ExpT18 - ExpT19 + ExpT20 - ExpT21 + ExpT22 - ExpT23 + ExpT24;

  // table entry k: ratio to the power k, rounded to Q0.16
  function automatic logic [15:0] exp_entry(input int k);
    longint unsigned e;
    longint unsigned q;
    e = 64'd1 << 31;
    for (int i = 0; i < k; i++) begin
      e = (e * ExpRatio) >> 31;
    end
    q = (e + (64'd1 << 14)) >> 15;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    if (x > 34'sh0_7FFF_FFFF) begin
      return Q32_MAX;
    end else if (x < -34'sh0_8000_0000) begin
      return Q32_MIN;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [50:0] x);
    if (x > 51'sh0_7FFF_FFFF_FFFF) begin
      return Q48_MAX;
    end else if (x < -51'sh0_8000_0000_0000) begin
      return Q48_MIN;
    end
    return x[47:0];
  endfunction

  function automatic logic signed [47:0] add48(input logic signed [47:0] a,
                                               input logic signed [47:0] b);
    logic signed [50:0] s;
    s = {{3{a[47]}}, a} + {{3{b[47]}}, b};
    return sat48(s);
  endfunction

  function automatic logic signed [32:0] ext33(input logic signed [31:0] x);
    return {x[31], x};
  endfunction

  // ---------------------------------------------------------------------
  // exp(-x) table, constant logic read through a registered index
  // ---------------------------------------------------------------------
  logic [15:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_exp
    localparam logic [15:0] Entry = exp_entry(gi);
    assign exp_rom[gi] = Entry;
  end

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic signed [31:0] density_flow_gain;
  logic signed [31:0] flow_density_gain;
  logic signed [31:0] smoothness_weight;
  logic signed [31:0] target_weight;
  logic signed [31:0] inverse_temperature;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      density_flow_gain   <= 32'sd65536;
      flow_density_gain   <= 32'sd65536;
      smoothness_weight   <= 32'sd65536;
      target_weight       <= 32'sd0;
      inverse_temperature <= 32'sd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DENSITY_FLOW_GAIN:   density_flow_gain   <= cfg_data;
        CFG_FLOW_DENSITY_GAIN:   flow_density_gain   <= cfg_data;
        CFG_SMOOTHNESS_WEIGHT:   smoothness_weight   <= cfg_data;
        CFG_TARGET_WEIGHT:       target_weight       <= cfg_data;
        CFG_INVERSE_TEMPERATURE: inverse_temperature <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------
  state_t state, state_next;

  item_t            item_q;
  logic [AddrW-1:0] cell_q;       // addressed cell
  logic             inside_q;     // cell lies in the grid
  logic             step_good_q;  // step with a site in range
  logic             bad_q;        // step with a site out of range
  phase_t           phase;
  op_idx_t          op_cnt;

  logic rd_issue;
  logic op_issue;
  logic finish;
  logic barrier;
  logic pipe_empty;

  logic    m1_valid, m2_valid, wb_valid;
  op_idx_t m1_op, m2_op, wb_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    rd_issue   = 1'b0;
    op_issue   = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        rd_issue = 1'b1;
        // only the center cell is needed unless the step is in range
        if (phase == PH_RIGHT || !step_good_q) begin
          state_next = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_next = step_good_q ? ST_CALC : ST_FINISH;
      end
      ST_CALC: begin
        op_issue = (op_cnt != OP_COUNT) && (!barrier || pipe_empty);
        if (wb_valid && wb_op == OP_ENERGY) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_TABLE;
      end
      ST_TABLE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!result_valid || result_ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // item capture and site check
  logic             item_fire;
  logic             in_grid;
  logic             site_bad;
  logic [AddrW-1:0] center;

  assign item_fire = item_valid && item_ready;
  assign in_grid   = (int'(item.row) < GRID_ROWS) && (int'(item.col) < GRID_COLS);
  assign site_bad  = (int'(item.row) < 2) || (int'(item.row) + 3 > GRID_ROWS) ||
                     (int'(item.col) < 2) || (int'(item.col) + 3 > GRID_COLS);
  assign center    = in_grid ? AddrW'(int'(item.row) * GRID_COLS + int'(item.col))
                             : '0;

  always_ff @(posedge clk) begin
    if (item_fire) begin
      item_q      <= item;
      cell_q      <= center;
      inside_q    <= in_grid;
      step_good_q <= (item.kind == KIND_STEP) && !site_bad;
      bad_q       <= (item.kind == KIND_STEP) && site_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CENTER;
    end else if (item_fire) begin
      phase <= PH_CENTER;
    end else if (rd_issue) begin
      phase <= phase + 3'd1;
    end
  end

  // ---------------------------------------------------------------------
  // grid memories
  // ---------------------------------------------------------------------
  logic [AddrW-1:0] flow_rd_addr;
  logic [AddrW-1:0] dens_rd_addr;
  logic             we_load;
  logic             we_step;
  logic             accept_now;
  logic [31:0]      dens_q, u_q, v_q, ut_q, vt_q;
  logic signed [31:0] new_u, new_v;
  logic signed [31:0] u_wr, v_wr;

  // flow reads step by two cells, density reads the nearest neighbours
  always_comb begin
    flow_rd_addr = cell_q;
    dens_rd_addr = cell_q;
    case (phase)
      PH_UP: begin
        flow_rd_addr = cell_q - Col2;
        dens_rd_addr = cell_q - Col1;
      end
      PH_DOWN: begin
        flow_rd_addr = cell_q + Col2;
        dens_rd_addr = cell_q + Col1;
      end
      PH_LEFT: begin
        flow_rd_addr = cell_q - Two;
        dens_rd_addr = cell_q - One;
      end
      PH_RIGHT: begin
        flow_rd_addr = cell_q + Two;
        dens_rd_addr = cell_q + One;
      end
      default: ;
    endcase
  end

  assign we_load = finish && (item_q.kind == KIND_LOAD) && inside_q;
  assign we_step = finish && accept_now;
  assign u_wr    = we_load ? item_q.target_u : new_u;
  assign v_wr    = we_load ? item_q.target_v : new_v;

  ffms_ram #(.WIDTH(32), .DEPTH(Cells)) u_dens_ram (
    .clk, .wr_en(we_load), .wr_addr(cell_q), .wr_data(item_q.density),
    .rd_addr(dens_rd_addr), .rd_data(dens_q)
  );

  ffms_ram #(.WIDTH(32), .DEPTH(Cells)) u_flow_u_ram (
    .clk, .wr_en(we_load || we_step), .wr_addr(cell_q), .wr_data(u_wr),
    .rd_addr(flow_rd_addr), .rd_data(u_q)
  );

  ffms_ram #(.WIDTH(32), .DEPTH(Cells)) u_flow_v_ram (
    .clk, .wr_en(we_load || we_step), .wr_addr(cell_q), .wr_data(v_wr),
    .rd_addr(flow_rd_addr), .rd_data(v_q)
  );

  ffms_ram #(.WIDTH(32), .DEPTH(Cells)) u_target_u_ram (
    .clk, .wr_en(we_load), .wr_addr(cell_q), .wr_data(item_q.target_u),
    .rd_addr(cell_q), .rd_data(ut_q)
  );

  ffms_ram #(.WIDTH(32), .DEPTH(Cells)) u_target_v_ram (
    .clk, .wr_en(we_load), .wr_addr(cell_q), .wr_data(item_q.target_v),
    .rd_addr(cell_q), .rd_data(vt_q)
  );

  // neighbourhood registers, filled one read phase at a time
  logic               rd_pend;
  phase_t             rd_phase;
  logic signed [31:0] u0, un, us, uw, ue;
  logic signed [31:0] v0, vn, vs, vw, ve;
  logic signed [31:0] rn, rs, rw, re;
  logic signed [31:0] ut0, vt0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_phase <= phase;
    end
    if (rd_pend) begin
      case (rd_phase)
        PH_CENTER: begin
          u0  <= u_q;
          v0  <= v_q;
          ut0 <= ut_q;
          vt0 <= vt_q;
        end
        PH_UP: begin
          un <= u_q;
          vn <= v_q;
          rn <= dens_q;
        end
        PH_DOWN: begin
          us <= u_q;
          vs <= v_q;
          rs <= dens_q;
        end
        PH_LEFT: begin
          uw <= u_q;
          vw <= v_q;
          rw <= dens_q;
        end
        PH_RIGHT: begin
          ue <= u_q;
          ve <= v_q;
          re <= dens_q;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // operand selection for the shared multiplier
  // ---------------------------------------------------------------------
  logic signed [47:0] raw [4];
  logic signed [47:0] dens_acc, smw, tgw, energy;
  logic signed [50:0] smooth_acc, tgt_acc;

  logic signed [32:0] grad [10];
  logic signed [32:0] stp  [10];
  logic signed [47:0] opnd_a;
  logic signed [31:0] opnd_b;
  logic signed [31:0] sq_x;
  logic [4:0]         sq_rel;
  logic [3:0]         sq_j;
  logic [4:0]         gain_rel;
  logic signed [32:0] ddiff;

  // the eight gradients that see the site change, then the target errors
  always_comb begin
    grad[0] = ext33(u0) - ext33(un);  stp[0] = ext33(item_q.trial_du);
    grad[1] = ext33(v0) - ext33(vn);  stp[1] = ext33(item_q.trial_dv);
    grad[2] = ext33(us) - ext33(u0);  stp[2] = -ext33(item_q.trial_du);
    grad[3] = ext33(vs) - ext33(v0);  stp[3] = -ext33(item_q.trial_dv);
    grad[4] = ext33(ue) - ext33(u0);  stp[4] = -ext33(item_q.trial_du);
    grad[5] = ext33(ve) - ext33(v0);  stp[5] = -ext33(item_q.trial_dv);
    grad[6] = ext33(u0) - ext33(uw);  stp[6] = ext33(item_q.trial_du);
    grad[7] = ext33(v0) - ext33(vw);  stp[7] = ext33(item_q.trial_dv);
    grad[8] = ext33(u0) - ext33(ut0); stp[8] = ext33(item_q.trial_du);
    grad[9] = ext33(v0) - ext33(vt0); stp[9] = ext33(item_q.trial_dv);
  end

  always_comb begin
    opnd_a   = '0;
    opnd_b   = '0;
    barrier  = 1'b0;
    sq_rel   = op_cnt - OP_SQ0;
    sq_j     = sq_rel[4:1];
    gain_rel = op_cnt - OP_GAIN0;
    sq_x     = '0;
    ddiff    = '0;
    if (op_cnt < OP_SQ0) begin
      case (op_cnt[1:0])
        2'd0: ddiff = ext33(rn) - ext33(rs);
        2'd1: ddiff = ext33(rw) - ext33(re);
        2'd2: ddiff = ext33(rs) - ext33(rn);
        default: ddiff = ext33(re) - ext33(rw);
      endcase
      opnd_a = {{16{item_q.trial_du[31]}}, item_q.trial_du};
      if (op_cnt[0]) begin
        opnd_a = {{16{item_q.trial_dv[31]}}, item_q.trial_dv};
      end
      opnd_b = sat32({ddiff[32], ddiff});
    end else if (op_cnt < OP_GAIN0) begin
      // even slot squares the moved gradient, odd slot the present one
      if (!sq_rel[0]) begin
        sq_x = sat32({grad[sq_j][32], grad[sq_j]} + {stp[sq_j][32], stp[sq_j]});
      end else begin
        sq_x = sat32({grad[sq_j][32], grad[sq_j]});
      end
      opnd_a = {{16{sq_x[31]}}, sq_x};
      opnd_b = sq_x;
    end else if (op_cnt < OP_SMW) begin
      opnd_a = raw[gain_rel[1:0]];
      opnd_b = gain_rel[1] ? flow_density_gain : density_flow_gain;
    end else if (op_cnt == OP_SMW) begin
      barrier = 1'b1;
      opnd_a  = sat48(smooth_acc);
      opnd_b  = smoothness_weight;
    end else if (op_cnt == OP_TGW) begin
      opnd_a = sat48(tgt_acc);
      opnd_b = target_weight;
    end else begin
      barrier = 1'b1;
      opnd_a  = add48(add48(dens_acc, smw), tgw);
      opnd_b  = inverse_temperature;
    end
  end

  // ---------------------------------------------------------------------
  // shared multiplier: magnitudes, split partial products, truncate and
  // saturate
  // ---------------------------------------------------------------------
  logic [47:0]        m1_a_abs;
  logic [31:0]        m1_b_abs;
  logic               m1_neg;
  logic [63:0]        m2_lo;
  logic [47:0]        m2_hi;
  logic               m2_neg;
  logic [79:0]        prod;
  logic [63:0]        prod_q16;
  logic signed [47:0] prod_res;
  logic signed [47:0] wb_res;

  assign pipe_empty = !(m1_valid || m2_valid || wb_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      wb_valid <= 1'b0;
      op_cnt   <= OP_RAW0;
    end else begin
      m1_valid <= op_issue;
      m2_valid <= m1_valid;
      wb_valid <= m2_valid;
      if (item_fire) begin
        op_cnt <= OP_RAW0;
      end else if (op_issue) begin
        op_cnt <= op_cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    m1_op    <= op_cnt;
    m1_a_abs <= opnd_a[47] ? 48'(-opnd_a) : opnd_a;
    m1_b_abs <= opnd_b[31] ? 32'(-opnd_b) : opnd_b;
    m1_neg   <= opnd_a[47] ^ opnd_b[31];
    m2_op    <= m1_op;
    m2_lo    <= 64'(m1_a_abs[31:0]) * 64'(m1_b_abs);
    m2_hi    <= 48'(m1_a_abs[47:32]) * 48'(m1_b_abs);
    m2_neg   <= m1_neg;
    wb_op    <= m2_op;
    wb_res   <= prod_res;
  end

  always_comb begin
    prod     = {16'd0, m2_lo} + {m2_hi, 32'd0};
    prod_q16 = prod[79:16];
    if (m2_neg) begin
      prod_res = (prod_q16 > 64'h0000_8000_0000_0000) ? Q48_MIN
                                                       : 48'(-prod_q16[47:0]);
    end else begin
      prod_res = (prod_q16 > 64'h0000_7FFF_FFFF_FFFF) ? Q48_MAX : prod_q16[47:0];
    end
  end

  // writeback of each product to its accumulator
  logic [4:0] wb_rel;

  assign wb_rel = wb_op - OP_SQ0;

  always_ff @(posedge clk) begin
    if (item_fire) begin
      dens_acc   <= '0;
      smooth_acc <= '0;
      tgt_acc    <= '0;
    end else if (wb_valid) begin
      if (wb_op < OP_SQ0) begin
        raw[wb_op[1:0]] <= wb_res;
      end else if (wb_op < OP_TGT0) begin
        smooth_acc <= wb_rel[0] ? smooth_acc - {{3{wb_res[47]}}, wb_res}
                                : smooth_acc + {{3{wb_res[47]}}, wb_res};
      end else if (wb_op < OP_GAIN0) begin
        tgt_acc <= wb_rel[0] ? tgt_acc - {{3{wb_res[47]}}, wb_res}
                             : tgt_acc + {{3{wb_res[47]}}, wb_res};
      end else if (wb_op < OP_SMW) begin
        dens_acc <= add48(dens_acc, wb_res);
      end else if (wb_op == OP_SMW) begin
        smw <= wb_res;
      end else if (wb_op == OP_TGW) begin
        tgw <= wb_res;
      end else begin
        energy <= wb_res;
      end
    end
  end

  // ---------------------------------------------------------------------
  // acceptance: sign, range and table lookup
  // ---------------------------------------------------------------------
  logic               e_neg, e_small;
  logic [ExpIdxW-1:0] exp_idx;
  logic [15:0]        exp_q;
  logic [33:0]        e_scaled;

  assign e_scaled = 34'(energy[19:0]) * 34'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      e_neg   <= energy[47];
      e_small <= (energy[47:20] == '0);
      exp_idx <= e_scaled[20 +: ExpIdxW];
    end
    if (state == ST_TABLE) begin
      exp_q <= exp_rom[exp_idx];
    end
  end

  assign accept_now = step_good_q &&
                      (e_neg || (e_small && (item_q.uniform_draw < exp_q)));
  assign new_u = sat32({{2{u0[31]}}, u0} +
                       {{2{item_q.trial_du[31]}}, item_q.trial_du});
  assign new_v = sat32({{2{v0[31]}}, v0} +
                       {{2{item_q.trial_dv[31]}}, item_q.trial_dv});

  // ---------------------------------------------------------------------
  // move count and result register
  // ---------------------------------------------------------------------
  logic [31:0] acc_cnt;
  logic [31:0] acc_cnt_next;

  assign acc_cnt_next = (we_step && acc_cnt != 32'hFFFF_FFFF) ? acc_cnt + 32'd1
                                                             : acc_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      acc_cnt <= acc_cnt_next;
      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.accepted      <= accept_now;
      result.bad_site      <= bad_q;
      result.energy_change <= step_good_q ? energy : '0;
      result.accept_total  <= acc_cnt_next;
      result.flow_u        <= '0;
      result.flow_v        <= '0;
      if (inside_q && item_q.kind != KIND_SPARE) begin
        if (item_q.kind == KIND_LOAD) begin
          result.flow_u <= item_q.target_u;
          result.flow_v <= item_q.target_v;
        end else if (accept_now) begin
          result.flow_u <= new_u;
          result.flow_v <= new_v;
        end else begin
          result.flow_u <= u0;
          result.flow_v <= v0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_count_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && acc_cnt != $past(acc_cnt)) |-> acc_cnt == $past(acc_cnt) + 32'd1)
    else $error("move count changed by other than one");

  a_bad_never_accepted: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.accepted && result.bad_site))
    else $error("out of range site reported as accepted");

  a_barrier_on_empty_pipe: assert property (@(posedge clk) disable iff (rst)
    (op_issue && barrier) |-> pipe_empty)
    else $error("dependent product issued before its inputs settled");

  a_write_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    (we_load || we_step) |-> (state == ST_FINISH && finish))
    else $error("grid written outside the final state");

endmodule

`default_nettype wire

// ----- rtl/ffms_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module ffms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- test/flow_field_metropolis_step_tb.sv -----
// testbench of the flow field metropolis step block with a self-checking model
`timescale 1ns / 100ps
`default_nettype none

module flow_field_metropolis_step_tb;
  import ffms_pkg::*;

  localparam int ROWS  = DEF_GRID_ROWS;
  localparam int COLS  = DEF_GRID_COLS;
  localparam int CELLS = ROWS * COLS;
  localparam int TDEPTH = DEF_EXP_TABLE_DEPTH;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 20000;   // cycles without any transaction

  logic clk = 1'b0;
  logic rst;
  logic item_valid, item_ready;
  item_t item;
  logic result_valid, result_ready;
  result_t result;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  flow_field_metropolis_step uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state of the sampler
  int dens_mem [CELLS];
  int u_mem [CELLS];
  int v_mem [CELLS];
  int ut_mem [CELLS];
  int vt_mem [CELLS];
  bit loaded [CELLS];
  logic [31:0] moves_taken;
  logic [15:0] exp_frac [TDEPTH];
  longint gain_df, gain_fd, w_smooth, w_target, beta;

  result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int steps_run = 0;
  int steps_taken = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clamp48(longint x);
    longint hi, lo;
    hi = 64'sh7FFF_FFFF_FFFF;
    lo = -64'sh8000_0000_0000;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // q16 product, truncated toward zero, clamped to 48 bit
  function automatic longint qmul(longint a, longint b);
    bit neg;
    longint unsigned ma, mb, p;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma >> 16) * mb + (((ma & 64'hFFFF) * mb) >> 16);
    if (neg) begin
      if (p > 64'h8000_0000_0000) return -64'sh8000_0000_0000;
      return -longint'(p);
    end
    if (p > 64'h7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    return longint'(p);
  endfunction

  function automatic longint qsquare(longint x);
    longint s;
    longint unsigned p;
    s = clamp32(x);
    p = s * s;
    return longint'(p >> 16);
  endfunction

  function automatic longint sq_change(longint g, longint d);
    return qsquare(g + d) - qsquare(g);
  endfunction

  function automatic int idx(int r, int c);
    return r * COLS + c;
  endfunction

  // exp(-16k/depth) table built by truncating products of a taylor ratio
  function automatic void build_exp_fracs();
    longint unsigned term, ratio, e, q;
    term = 64'd1 << 31;
    ratio = term;
    e = term;
    for (int n = 1; n <= 24; n++) begin
      term = term * 16 / (longint'(TDEPTH) * n);
      if (n % 2) ratio = ratio - term;
      else ratio = ratio + term;
    end
    for (int k = 0; k < TDEPTH; k++) begin
      q = (e + (64'd1 << 14)) >> 15;
      exp_frac[k] = (q > 65535) ? 16'hFFFF : q[15:0];
      e = (e * ratio) >> 31;
    end
  endfunction

  function automatic void model_reset();
    moves_taken = '0;
    gain_df = 65536;
    gain_fd = 65536;
    w_smooth = 65536;
    w_target = 0;
    beta = 65536;
    build_exp_fracs();
  endfunction

  function automatic void model_config(cfg_reg_t r, logic [31:0] d);
    longint v;
    v = longint'(signed'(d));
    case (r)
      CFG_DENSITY_FLOW_GAIN:   gain_df = v;
      CFG_FLOW_DENSITY_GAIN:   gain_fd = v;
      CFG_SMOOTHNESS_WEIGHT:   w_smooth = v;
      CFG_TARGET_WEIGHT:       w_target = v;
      CFG_INVERSE_TEMPERATURE: beta = v;
      default: ;
    endcase
  endfunction

  // energy change of one proposed move at an interior site
  function automatic longint move_energy(int r, int c, longint du, longint dv);
    longint dens, smooth, tgt, rv, rn;
    int k;
    k = idx(r, c);
    rv = clamp32(longint'(dens_mem[idx(r-1, c)]) - dens_mem[idx(r+1, c)]);
    rn = clamp32(longint'(dens_mem[idx(r, c-1)]) - dens_mem[idx(r, c+1)]);
    dens = qmul(qmul(du, rv), gain_df);
    dens = clamp48(dens + qmul(qmul(dv, rn), gain_df));
    dens = clamp48(dens + qmul(qmul(du, clamp32(-(longint'(dens_mem[idx(r-1, c)])
      - dens_mem[idx(r+1, c)]))), gain_fd));
    dens = clamp48(dens + qmul(qmul(dv, clamp32(-(longint'(dens_mem[idx(r, c-1)])
      - dens_mem[idx(r, c+1)]))), gain_fd));
    smooth = sq_change(longint'(u_mem[k]) - u_mem[idx(r-2, c)], du)
           + sq_change(longint'(v_mem[k]) - v_mem[idx(r-2, c)], dv)
           + sq_change(longint'(u_mem[idx(r+2, c)]) - u_mem[k], -du)
           + sq_change(longint'(v_mem[idx(r+2, c)]) - v_mem[k], -dv)
           + sq_change(longint'(u_mem[idx(r, c+2)]) - u_mem[k], -du)
           + sq_change(longint'(v_mem[idx(r, c+2)]) - v_mem[k], -dv)
           + sq_change(longint'(u_mem[k]) - u_mem[idx(r, c-2)], du)
           + sq_change(longint'(v_mem[k]) - v_mem[idx(r, c-2)], dv);
    smooth = qmul(clamp48(smooth), w_smooth);
    tgt = sq_change(longint'(u_mem[k]) - ut_mem[k], du)
        + sq_change(longint'(v_mem[k]) - vt_mem[k], dv);
    tgt = qmul(clamp48(tgt), w_target);
    return qmul(clamp48(clamp48(dens + smooth) + tgt), beta);
  endfunction

  // expected result of one item, updating the model grids
  function automatic result_t predict_flow(item_t t);
    result_t res;
    int r, c, k;
    longint du, dv, en;
    bit take;
    res = '0;
    r = t.row;
    c = t.col;
    k = idx(r, c);
    if (t.kind == KIND_LOAD) begin
      dens_mem[k] = t.density;
      u_mem[k] = t.target_u;
      ut_mem[k] = t.target_u;
      v_mem[k] = t.target_v;
      vt_mem[k] = t.target_v;
    end else if (t.kind == KIND_STEP) begin
      if (r < 2 || r > ROWS - 3 || c < 2 || c > COLS - 3) begin
        res.bad_site = 1'b1;
      end else begin
        du = longint'(t.trial_du);
        dv = longint'(t.trial_dv);
        en = move_energy(r, c, du, dv);
        take = 1'b0;
        if (en < 0) take = 1'b1;
        else if (en < (64'sd1 << 20))
          take = t.uniform_draw < exp_frac[(en * TDEPTH) >>> 20];
        if (take) begin
          u_mem[k] = int'(clamp32(longint'(u_mem[k]) + du));
          v_mem[k] = int'(clamp32(longint'(v_mem[k]) + dv));
          if (moves_taken != 32'hFFFF_FFFF) moves_taken++;
        end
        res.accepted = take;
        res.energy_change = en[47:0];
      end
    end
    if (t.kind != KIND_SPARE) begin
      res.flow_u = u_mem[k];
      res.flow_v = v_mem[k];
    end
    res.accept_total = moves_taken;
    return res;
  endfunction

  // receiver: random backpressure
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // checker: each result transaction against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.accepted !== result.accepted) begin
          $display("%0t: accepted exp %0d got %0d", $time, want.accepted, result.accepted);
          errors++;
        end
        if (want.bad_site !== result.bad_site) begin
          $display("%0t: bad_site exp %0d got %0d", $time, want.bad_site, result.bad_site);
          errors++;
        end
        if (want.energy_change !== result.energy_change) begin
          $display("%0t: energy_change exp %h got %h", $time,
                   want.energy_change, result.energy_change);
          errors++;
        end
        if (want.flow_u !== result.flow_u) begin
          $display("%0t: flow_u exp %h got %h", $time, want.flow_u, result.flow_u);
          errors++;
        end
        if (want.flow_v !== result.flow_v) begin
          $display("%0t: flow_v exp %h got %h", $time, want.flow_v, result.flow_v);
          errors++;
        end
        if (want.accept_total !== result.accept_total) begin
          $display("%0t: accept_total exp %0d got %0d", $time,
                   want.accept_total, result.accept_total);
          errors++;
        end
      end
    end
  end

  // watchdog: too long with no transaction on any channel
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // send one item; valid stays high between back to back transactions
  task automatic send_item(item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= t;
    do @(posedge clk); while (!item_ready);
    pending_results.push_back(predict_flow(t));
    items_sent++;
    if (t.kind == KIND_STEP) steps_run++;
  endtask

  // mostly small q16 values, sometimes any 32 bit pattern
  function automatic logic [31:0] pick_q(int span);
    if ($urandom_range(99) < 80) return $urandom_range(2 * span) - span;
    return $urandom;
  endfunction

  task automatic load_cell(int r, int c);
    item_t t;
    t = '0;
    t.kind = KIND_LOAD;
    t.row = r;
    t.col = c;
    t.density = pick_q(131072);
    t.target_u = pick_q(65536);
    t.target_v = pick_q(65536);
    t.trial_du = $urandom;
    t.uniform_draw = $urandom;
    send_item(t);
    loaded[idx(r, c)] = 1'b1;
  endtask

  task automatic need_cell(int r, int c);
    if (!loaded[idx(r, c)]) load_cell(r, c);
  endtask

  // a good step needs its whole cross of distance one and two loaded
  task automatic step_at(int r, int c, logic [31:0] du, logic [31:0] dv, logic [15:0] draw);
    item_t t;
    if (r >= 2 && r <= ROWS - 3 && c >= 2 && c <= COLS - 3) begin
      for (int o = -2; o <= 2; o++) begin
        need_cell(r + o, c);
        need_cell(r, c + o);
      end
    end else begin
      need_cell(r, c);
    end
    t = '0;
    t.kind = KIND_STEP;
    t.row = r;
    t.col = c;
    t.trial_du = du;
    t.trial_dv = dv;
    t.uniform_draw = draw;
    t.density = $urandom;
    send_item(t);
  endtask

  task automatic read_cell(int r, int c, kind_t k);
    item_t t;
    if (k != KIND_SPARE) need_cell(r, c);
    t = '0;
    t.kind = k;
    t.row = r;
    t.col = c;
    t.target_u = $urandom;
    send_item(t);
  endtask

  // wait until every expected result is in, then let the block settle
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_config(r, d);
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] a, logic [31:0] b, logic [31:0] s,
                          logic [31:0] g, logic [31:0] tmp);
    drain();
    write_reg(CFG_DENSITY_FLOW_GAIN, a);
    write_reg(CFG_FLOW_DENSITY_GAIN, b);
    write_reg(CFG_SMOOTHNESS_WEIGHT, s);
    write_reg(CFG_TARGET_WEIGHT, g);
    write_reg(CFG_INVERSE_TEMPERATURE, tmp);
  endtask

  // corners, extremes, spare kind, bad sites, zero and huge moves
  task automatic test_directed();
    item_t t;
    t = '0;
    t.kind = KIND_LOAD;
    t.density = 32'h7FFF_FFFF;
    t.target_u = 32'h8000_0000;
    t.target_v = 32'h7FFF_FFFF;
    send_item(t);
    loaded[idx(0, 0)] = 1'b1;
    t.row = 6'd63;
    t.col = 6'd63;
    t.density = 32'h8000_0000;
    t.target_u = 32'h7FFF_FFFF;
    t.target_v = 32'h8000_0000;
    send_item(t);
    loaded[idx(63, 63)] = 1'b1;
    read_cell(0, 0, KIND_READ);
    read_cell(63, 63, KIND_READ);
    read_cell(63, 63, KIND_SPARE);
    step_at(0, 0, 32'h0001_0000, 32'h0001_0000, 16'd0);
    step_at(63, 63, 32'h0001_0000, 32'h0001_0000, 16'd0);
    // zero move: energy zero, the draw against the first table entry decides
    step_at(2, 2, 32'h0, 32'h0, 16'hFFFF);
    step_at(2, 2, 32'h0, 32'h0, 16'h0000);
    // huge increments saturate the flow and the energy
    step_at(2, 2, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
    step_at(2, 2, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    step_at(61, 61, 32'h0000_4000, 32'hFFFF_C000, 16'h8000);
    read_cell(2, 2, KIND_READ);
  endtask

  // mostly a small corner window, so neighbourhood loads stay few
  function automatic int pick_coord();
    if ($urandom_range(99) < 97) return $urandom_range(11);
    return $urandom_range(63);
  endfunction

  // random traffic: mostly well formed steps on loaded neighbourhoods
  task automatic test_random(int count);
    int sel, r, c;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      r = pick_coord();
      c = pick_coord();
      if (sel < 20) begin
        load_cell(r, c);
      end else if (sel < 32) begin
        read_cell(r, c, KIND_READ);
      end else if (sel < 36) begin
        read_cell(r, c, KIND_SPARE);
      end else if (sel < 42) begin
        step_at(r, c, pick_q(32768), pick_q(32768), $urandom);
      end else begin
        r = (r < 2) ? 2 : (r > ROWS - 3 ? ROWS - 3 : r);
        c = (c < 2) ? 2 : (c > COLS - 3 ? COLS - 3 : c);
        step_at(r, c, pick_q(16384), pick_q(16384), $urandom);
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DENSITY_FLOW_GAIN;
    cfg_data <= '0;
    model_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();

    // sender idles less than the receiver
    send_idle_pct = 12;
    recv_idle_pct = 50;
    set_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    test_random(65);
    set_regs(32'h0000_4000, 32'hFFFF_8000, 32'h0000_2000, 32'h0000_8000, 32'h0004_0000);
    test_random(65);

    // receiver idles less than the sender
    send_idle_pct = 50;
    recv_idle_pct = 12;
    set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100);
    test_random(65);
    // zero inverse temperature: every good move has zero energy
    set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    test_random(65);

    // full throughput
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(32'h0, 32'h0, 32'h0000_1000, 32'h0, 32'h8000_0000);
    test_random(65);
    set_regs($urandom, $urandom, $urandom, $urandom, $urandom_range(262144));
    test_random(65);

    drain();
    $display("ran %0d items, %0d steps with %0d moves taken, over six register settings",
             items_sent, steps_run, moves_taken);
    $display("register extremes, both idling mixes and full rate were covered");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/ffms_pkg.sv
rtl/ffms_ram.sv
rtl/flow_field_metropolis_step.sv
test/flow_field_metropolis_step_tb.sv
